@@ rtl/lmr_pkg.sv @@
// ----------------------------------------------------------------------------
// lmr_pkg: shared types, microcode and saturation helpers
// Holds the control word format, the sequencer program and the arithmetic
// helpers used by the metric reduction datapath.
// ----------------------------------------------------------------------------
package lmr_pkg;

	localparam int unsigned STEP_W = 3;

	typedef logic [STEP_W-1:0] step_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_LOAD    = 3'd0,
		OP_CHECK   = 3'd1,
		OP_NEG     = 3'd2,
		OP_SWAP    = 3'd3,
		OP_SHEAR_A = 3'd4,
		OP_SHEAR_B = 3'd5,
		OP_PASS    = 3'd6,
		OP_EMIT    = 3'd7
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		COND_NONE     = 3'd0,
		COND_ALWAYS   = 3'd1,
		COND_NO_IN    = 3'd2,
		COND_EXIT     = 3'd3,
		COND_NO_SHEAR = 3'd4,
		COND_OUT_FULL = 3'd5
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	// control from sequencer to datapath
	typedef struct packed {
		op_t  op;
		logic en;
	} dp_ctrl_t;

	// status from datapath to sequencer
	typedef struct packed {
		logic reduced;
		logic shear_due;
	} dp_stat_t;

	localparam step_t STEP_IDLE    = 3'd0;
	localparam step_t STEP_CHECK   = 3'd1;
	localparam step_t STEP_NEG     = 3'd2;
	localparam step_t STEP_SWAP    = 3'd3;
	localparam step_t STEP_SHEAR_A = 3'd4;
	localparam step_t STEP_SHEAR_B = 3'd5;
	localparam step_t STEP_PASS    = 3'd6;
	localparam step_t STEP_EMIT    = 3'd7;

	localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [15:0] M_MAX = 16'sh7FFF;
	localparam logic signed [15:0] M_MIN = 16'sh8000;
	localparam logic signed [15:0] M_ONE = 16'sd1;
	localparam logic signed [15:0] M_ZERO = 16'sd0;

	// sequencer program; falling through from the last step wraps to idle
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		unique case (s)
			STEP_IDLE:    w = '{op: OP_LOAD,    cond: COND_NO_IN,    target: STEP_IDLE};
			STEP_CHECK:   w = '{op: OP_CHECK,   cond: COND_EXIT,     target: STEP_EMIT};
			STEP_NEG:     w = '{op: OP_NEG,     cond: COND_NONE,     target: STEP_IDLE};
			STEP_SWAP:    w = '{op: OP_SWAP,    cond: COND_NONE,     target: STEP_IDLE};
			STEP_SHEAR_A: w = '{op: OP_SHEAR_A, cond: COND_NO_SHEAR, target: STEP_PASS};
			STEP_SHEAR_B: w = '{op: OP_SHEAR_B, cond: COND_NONE,     target: STEP_IDLE};
			STEP_PASS:    w = '{op: OP_PASS,    cond: COND_ALWAYS,   target: STEP_CHECK};
			STEP_EMIT:    w = '{op: OP_EMIT,    cond: COND_OUT_FULL, target: STEP_EMIT};
			default:      w = '{op: OP_LOAD,    cond: COND_NONE,     target: STEP_IDLE};
		endcase
		return w;
	endfunction

	// clamp a wide exact value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sh0_7FFF_FFFF)
			r = C_MAX;
		else if (v < -36'sh0_8000_0000)
			r = C_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

	// clamp to the signed 16-bit range
	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		logic signed [15:0] r;
		if (v > 17'sh0_7FFF)
			r = M_MAX;
		else if (v < -17'sh0_8000)
			r = M_MIN;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

@@ rtl/lmr_datapath.sv @@
// ----------------------------------------------------------------------------
// lmr_datapath: metric entries, transform matrix and shear count
// Plain register datapath; one operation per cycle while enabled, as chosen
// by the sequencer's control word.
// ----------------------------------------------------------------------------
module lmr_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lmr_pkg::dp_ctrl_t       ctrl,
	input  logic signed [31:0]      c11_in,
	input  logic signed [31:0]      c22_in,
	input  logic signed [31:0]      c12_in,
	output lmr_pkg::dp_stat_t       stat,
	output logic signed [31:0]      a,
	output logic signed [31:0]      b,
	output logic signed [31:0]      c,
	output logic signed [15:0]      m00,
	output logic signed [15:0]      m01,
	output logic signed [15:0]      m10,
	output logic signed [15:0]      m11,
	output logic [7:0]              shears
);

	logic signed [31:0] a_q, b_q, c_q;
	logic signed [15:0] m00_q, m01_q, m10_q, m11_q;
	logic [7:0]         shears_q;
	logic signed [34:0] t_q;

	logic signed [32:0] c2;
	logic signed [31:0] c_neg;
	logic signed [34:0] t_next;
	logic signed [35:0] b_sum;
	logic signed [32:0] c_diff;

	// domain tests on the current entries
	assign c2 = {c_q, 1'b0};
	assign stat.reduced   = !c_q[31] && (b_q >= a_q) && (c2 <= 33'(a_q));
	assign stat.shear_due = c2 > 33'(a_q);

	// negation of the off-diagonal entry, most negative maps to most positive
	assign c_neg = (c_q == lmr_pkg::C_MIN) ? lmr_pkg::C_MAX : -c_q;

	// shear arithmetic split over two steps: b - 2c, then + a
	assign t_next = 35'(b_q) - 35'(c2);
	assign b_sum  = 36'(t_q) + 36'(a_q);
	assign c_diff = 33'(c_q) - 33'(a_q);

	// register updates per operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q      <= '0;
			b_q      <= '0;
			c_q      <= '0;
			m00_q    <= lmr_pkg::M_ONE;
			m01_q    <= lmr_pkg::M_ZERO;
			m10_q    <= lmr_pkg::M_ZERO;
			m11_q    <= lmr_pkg::M_ONE;
			t_q      <= '0;
			shears_q <= '0;
		end else if (ctrl.en) begin
			unique case (ctrl.op)
				lmr_pkg::OP_LOAD: begin
					a_q      <= c11_in;
					b_q      <= c22_in;
					c_q      <= c12_in;
					m00_q    <= lmr_pkg::M_ONE;
					m01_q    <= lmr_pkg::M_ZERO;
					m10_q    <= lmr_pkg::M_ZERO;
					m11_q    <= lmr_pkg::M_ONE;
					shears_q <= '0;
				end
				lmr_pkg::OP_NEG: begin
					if (c_q[31]) begin
						c_q   <= c_neg;
						m01_q <= lmr_pkg::sat16(-17'(m01_q));
						m11_q <= lmr_pkg::sat16(-17'(m11_q));
					end
				end
				lmr_pkg::OP_SWAP: begin
					if (b_q < a_q) begin
						a_q   <= b_q;
						b_q   <= a_q;
						m00_q <= m01_q;
						m01_q <= m00_q;
						m10_q <= m11_q;
						m11_q <= m10_q;
					end
				end
				lmr_pkg::OP_SHEAR_A: begin
					t_q <= t_next;
				end
				lmr_pkg::OP_SHEAR_B: begin
					b_q   <= lmr_pkg::sat32(b_sum);
					c_q   <= lmr_pkg::sat32(36'(c_diff));
					m01_q <= lmr_pkg::sat16(17'(m01_q) - 17'(m00_q));
					m11_q <= lmr_pkg::sat16(17'(m11_q) - 17'(m10_q));
					if (shears_q != 8'hFF)
						shears_q <= shears_q + 8'd1;
				end
				lmr_pkg::OP_CHECK, lmr_pkg::OP_PASS, lmr_pkg::OP_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign a      = a_q;
	assign b      = b_q;
	assign c      = c_q;
	assign m00    = m00_q;
	assign m01    = m01_q;
	assign m10    = m10_q;
	assign m11    = m11_q;
	assign shears = shears_q;

endmodule

@@ rtl/lagrange_metric_reduction_core.sv @@
// ----------------------------------------------------------------------------
// lagrange_metric_reduction_core: Lagrange reduction of a 2x2 metric
// Microcoded sequencer around a small add/compare datapath; reduces a
// symmetric Q16.16 metric to its fundamental domain with transform matrix.
// ----------------------------------------------------------------------------
// One item is in work at a time. The pass count is data dependent and capped
// by the smaller of the configured limit (limit_q) and MAX_LIMIT. The 8-step
// microcode program runs one step per cycle, holding in idle while no item
// is taken and in emit while the output is full, through a single shared
// adder datapath. The result sits in an output register, so the next item
// is taken while it waits to be collected.
module lagrange_metric_reduction_core #(
	parameter int unsigned MAX_LIMIT = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] c11_in,
	input  logic signed [31:0] c22_in,
	input  logic signed [31:0] c12_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] c11_out,
	output logic signed [31:0] c22_out,
	output logic signed [31:0] c12_out,
	output logic signed [15:0] m_top_left,
	output logic signed [15:0] m_top_right,
	output logic signed [15:0] m_bottom_left,
	output logic signed [15:0] m_bottom_right,
	output logic [7:0]         shear_count,
	output logic               shear_seen,
	output logic               limit_reached
);

	localparam int unsigned PASS_W = $clog2(MAX_LIMIT + 1);
	localparam int unsigned CMP_W  = (PASS_W > 8) ? PASS_W : 8;

	logic [7:0]           limit_q;
	logic [PASS_W-1:0]    pass_q;
	lmr_pkg::step_t       step_q;
	lmr_pkg::ucode_t      uw;
	lmr_pkg::dp_ctrl_t    ctrl;
	lmr_pkg::dp_stat_t    stat;
	logic                 in_acc;
	logic                 out_full;
	logic                 exit_now;
	logic                 jump;
	logic [CMP_W-1:0]     limit_eff;

	logic signed [31:0] a, b, c;
	logic signed [15:0] m00, m01, m10, m11;
	logic [7:0]         shears;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= 8'd64;
		else if (cfg_we)
			limit_q <= cfg_data;
	end

	// limit in use is the smaller of the register and the parameter
	assign limit_eff = (CMP_W'(limit_q) > CMP_W'(MAX_LIMIT)) ? CMP_W'(MAX_LIMIT)
	                                                         : CMP_W'(limit_q);

	// current control word
	assign uw       = lmr_pkg::ucode_rom(step_q);
	assign in_stall = (uw.op != lmr_pkg::OP_LOAD);
	assign in_acc   = in_valid && !in_stall;
	assign out_full = out_valid && out_stall;
	assign exit_now = stat.reduced || (CMP_W'(pass_q) >= limit_eff);

	// jump condition select
	always_comb begin
		unique case (uw.cond)
			lmr_pkg::COND_NONE:     jump = 1'b0;
			lmr_pkg::COND_ALWAYS:   jump = 1'b1;
			lmr_pkg::COND_NO_IN:    jump = !in_acc;
			lmr_pkg::COND_EXIT:     jump = exit_now;
			lmr_pkg::COND_NO_SHEAR: jump = !stat.shear_due;
			lmr_pkg::COND_OUT_FULL: jump = out_full;
			default:                jump = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= lmr_pkg::STEP_IDLE;
		else if (jump)
			step_q <= uw.target;
		else
			step_q <= step_q + lmr_pkg::step_t'(1);
	end

	// pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pass_q <= '0;
		else if (in_acc)
			pass_q <= '0;
		else if (uw.op == lmr_pkg::OP_PASS)
			pass_q <= pass_q + PASS_W'(1);
	end

	// datapath enable: load only when an item is taken
	assign ctrl.op = uw.op;
	assign ctrl.en = (uw.op != lmr_pkg::OP_LOAD) || in_acc;

	lmr_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.c11_in (c11_in),
		.c22_in (c22_in),
		.c12_in (c12_in),
		.stat   (stat),
		.a      (a),
		.b      (b),
		.c      (c),
		.m00    (m00),
		.m01    (m01),
		.m10    (m10),
		.m11    (m11),
		.shears (shears)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (uw.op == lmr_pkg::OP_EMIT && !out_full)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (uw.op == lmr_pkg::OP_EMIT && !out_full) begin
			c11_out        <= a;
			c22_out        <= b;
			c12_out        <= c;
			m_top_left     <= m00;
			m_top_right    <= m01;
			m_bottom_left  <= m10;
			m_bottom_right <= m11;
			shear_count    <= shears;
			shear_seen     <= (shears != 8'd0);
			limit_reached  <= !stat.reduced;
		end
	end

endmodule
